>>> hw/rtl/ues_pkg.sv
// Shared types and constants of the ultrasonic echo scanner.
// Used by every module of the block and by its checker.
package ues_pkg;

   localparam int NUM_SENSORS  = 4;
   localparam int SENSOR_LIMIT = (NUM_SENSORS > 4) ? 4 : NUM_SENSORS;
   localparam int VALID_LIMIT  = 150;

   localparam int REQ_WIDTH  = 8;
   localparam int RSP_WIDTH  = 16;
   localparam int CSR_AWIDTH = 3;
   localparam int CSR_DWIDTH = 32;

   localparam logic [16:0] TOTAL_MAX = 17'h1FFFF;

   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   localparam logic [CSR_AWIDTH-1:0] CSR_STABILITY  = 3'd0;
   localparam logic [CSR_AWIDTH-1:0] CSR_WIN_LOW    = 3'd1;
   localparam logic [CSR_AWIDTH-1:0] CSR_WIN_HIGH   = 3'd2;
   localparam logic [CSR_AWIDTH-1:0] CSR_PULSE_TO   = 3'd3;
   localparam logic [CSR_AWIDTH-1:0] CSR_TRIG_WIDTH = 3'd4;
   localparam logic [CSR_AWIDTH-1:0] CSR_GAP        = 3'd5;
   localparam logic [CSR_AWIDTH-1:0] CSR_SEARCH_TO  = 3'd6;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_TRIG = 3'd1,
      PH_RISE = 3'd2,
      PH_FALL = 3'd3,
      PH_GAP  = 3'd4
   } phase_type;

   typedef struct packed {
      logic [15:0] min_reads;
      logic [7:0]  window_low;
      logic [7:0]  window_high;
      logic [15:0] pulse_timeout;
      logic [7:0]  trigger_width;
      logic [19:0] gap_ticks;
      logic [31:0] search_timeout;
   } cfg_type;

   typedef struct packed {
      logic [1:0] op;
      logic [3:0] echo_levels;
      logic [1:0] sensor_select;
   } req_type;

   typedef struct packed {
      logic [3:0] trigger_lines;
      logic       done_res;
      logic       found;
      logic [1:0] sensor_found;
      logic [7:0] duration;
   } rsp_type;

endpackage

>>> hw/rtl/ues_csr.sv
// Configuration register file of the ultrasonic echo scanner.
// Depends on ues_pkg for the register indexes and the cfg_type bundle.
module ues_csr
   import ues_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_AWIDTH-1:0] csr_addr,
   input  logic [CSR_DWIDTH-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_STABILITY:  cfg_in.min_reads       = csr_wdata[15:0];
            CSR_WIN_LOW:    cfg_in.window_low      = csr_wdata[7:0];
            CSR_WIN_HIGH:   cfg_in.window_high     = csr_wdata[7:0];
            CSR_PULSE_TO:   cfg_in.pulse_timeout   = csr_wdata[15:0];
            CSR_TRIG_WIDTH: cfg_in.trigger_width   = csr_wdata[7:0];
            CSR_GAP:        cfg_in.gap_ticks       = csr_wdata[19:0];
            CSR_SEARCH_TO:  cfg_in.search_timeout  = csr_wdata[31:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_reads       <= 16'd0;
         cfg_ff.window_low      <= 8'd10;
         cfg_ff.window_high     <= 8'd80;
         cfg_ff.pulse_timeout   <= 16'd500;
         cfg_ff.trigger_width   <= 8'd10;
         cfg_ff.gap_ticks       <= 20'd1000;
         cfg_ff.search_timeout  <= 32'd10100000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/ues_engine.sv
// Read and search sequencer: holds the scan state and computes one tick per step.
// Depends on ues_pkg for phase_type, cfg_type, req_type and rsp_type.
module ues_engine
   import ues_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  cfg_type cfg,
   input  req_type req,
   output rsp_type rsp
);

   phase_type   phase_ff, phase_in;
   logic        mode_ff, mode_in;
   logic [1:0]  sensor_ff, sensor_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] rise_ff, rise_in;
   logic [16:0] total_ff, total_in;
   logic [19:0] gap_ff, gap_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic        timeout_ff, timeout_in;

   logic        level;
   logic        wrap;
   logic [15:0] count_adv;
   logic        do_begin;
   logic        do_finish;
   logic        do_after;
   logic [7:0]  raw;
   logic [7:0]  dur_ok;

   logic [3:0]  res_trig;
   logic        res_done;
   logic        res_found;
   logic [1:0]  res_sensor;
   logic [7:0]  res_dur;

   // The read counter runs up to pulse_timeout and then wraps to zero.
   assign wrap      = (count_ff >= cfg.pulse_timeout);
   assign count_adv = wrap ? 16'd0 : count_ff + 16'd1;
   assign level     = req.echo_levels[sensor_ff];

   // Next-state logic.
   always_comb begin
      phase_in   = phase_ff;
      mode_in    = mode_ff;
      sensor_in  = sensor_ff;
      count_in   = count_ff;
      rise_in    = rise_ff;
      total_in   = total_ff;
      gap_in     = gap_ff;
      elapsed_in = elapsed_ff;
      timeout_in = timeout_ff;
      res_trig   = 4'd0;
      res_done   = 1'b0;
      res_found  = 1'b0;
      res_sensor = 2'd0;
      res_dur    = 8'd0;
      do_begin   = 1'b0;
      do_finish  = 1'b0;
      do_after   = 1'b0;
      raw        = 8'd0;
      dur_ok     = 8'd0;

      if (phase_ff == PH_IDLE) begin
         if (req.op == OP_SEARCH) begin
            mode_in    = 1'b1;
            sensor_in  = 2'd0;
            total_in   = 17'd0;
            elapsed_in = 32'd1;
            do_begin   = 1'b1;
         end else if (req.op == OP_READ) begin
            mode_in   = 1'b0;
            sensor_in = req.sensor_select;
            if ({1'b0, req.sensor_select} >= 3'(SENSOR_LIMIT)) begin
               res_done = 1'b1;
            end else begin
               do_begin = 1'b1;
            end
         end
      end else begin
         if (mode_ff && (elapsed_ff != 32'hFFFF_FFFF)) begin
            elapsed_in = elapsed_ff + 32'd1;
         end
         unique case (phase_ff)
            PH_TRIG: begin
               res_trig   = 4'b0001 << sensor_ff;
               count_in   = count_adv;
               timeout_in = timeout_ff | wrap;
               gap_in     = gap_ff + 20'd1;
               if (gap_in >= {12'd0, cfg.trigger_width}) begin
                  phase_in = PH_RISE;
               end
            end
            PH_RISE: begin
               if (timeout_ff) begin
                  do_finish = 1'b1;
               end else begin
                  if (level) begin
                     rise_in  = count_ff;
                     phase_in = PH_FALL;
                  end
                  count_in   = count_adv;
                  timeout_in = timeout_ff | wrap;
               end
            end
            PH_FALL: begin
               if (!level) begin
                  do_finish = 1'b1;
                  raw       = count_ff[7:0] - rise_ff[7:0] - cfg.trigger_width;
               end else begin
                  count_in   = count_adv;
                  timeout_in = timeout_ff | wrap;
               end
            end
            PH_GAP: begin
               gap_in = gap_ff + 20'd1;
               if (gap_in >= cfg.gap_ticks) begin
                  do_after = 1'b1;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end

      if (do_finish) begin
         dur_ok = ((raw != 8'd0) && (raw < 8'(VALID_LIMIT))) ? raw : 8'd0;
         if (!mode_ff) begin
            phase_in = PH_IDLE;
            res_done = 1'b1;
            res_dur  = dur_ok;
         end else if ((dur_ok > cfg.window_low) && (dur_ok < cfg.window_high)
                      && (total_ff > {1'b0, cfg.min_reads})) begin
            phase_in   = PH_IDLE;
            res_done   = 1'b1;
            res_found  = 1'b1;
            res_sensor = sensor_ff;
            res_dur    = dur_ok;
         end else if (cfg.gap_ticks == 20'd0) begin
            do_after = 1'b1;
         end else begin
            phase_in = PH_GAP;
            gap_in   = 20'd0;
         end
      end

      if (do_after) begin
         if (({1'b0, sensor_ff} + 3'd1) >= 3'(SENSOR_LIMIT)) begin
            if (elapsed_in >= cfg.search_timeout) begin
               phase_in = PH_IDLE;
               res_done = 1'b1;
            end else begin
               sensor_in = 2'd0;
               do_begin  = 1'b1;
            end
         end else begin
            sensor_in = sensor_ff + 2'd1;
            do_begin  = 1'b1;
         end
      end

      // A new read starts with its first trigger tick on the same word.
      if (do_begin) begin
         phase_in   = (cfg.trigger_width <= 8'd1) ? PH_RISE : PH_TRIG;
         count_in   = (cfg.pulse_timeout == 16'd0) ? 16'd0 : 16'd1;
         timeout_in = (cfg.pulse_timeout == 16'd0);
         gap_in     = 20'd1;
         if (mode_in && (total_in != TOTAL_MAX)) begin
            total_in = total_in + 17'd1;
         end
         res_trig = 4'b0001 << sensor_in;
      end
   end

   // Output logic.
   always_comb begin
      rsp.trigger_lines = res_trig;
      rsp.done_res      = res_done;
      rsp.found         = res_found;
      rsp.sensor_found  = res_sensor;
      rsp.duration      = res_dur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         mode_ff    <= 1'b0;
         sensor_ff  <= 2'd0;
         count_ff   <= 16'd0;
         rise_ff    <= 16'd0;
         total_ff   <= 17'd0;
         gap_ff     <= 20'd0;
         elapsed_ff <= 32'd0;
         timeout_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         mode_ff    <= mode_in;
         sensor_ff  <= sensor_in;
         count_ff   <= count_in;
         rise_ff    <= rise_in;
         total_ff   <= total_in;
         gap_ff     <= gap_in;
         elapsed_ff <= elapsed_in;
         timeout_ff <= timeout_in;
      end
   end

endmodule

>>> hw/rtl/ultrasonic_echo_scanner.sv
// Channel   Direction  Width  Contents
// req_      in         8      op, echo_levels, sensor_select
// rsp_      out        16     trigger_lines, done_res, found, sensor_found, duration
// csr_      in         3+32   register index and write data, no read-back
//
// Each word passes from acceptance through the input register, where the sequencer
// computes the tick, and then through the result register.
// The sequencer steps once per word: one word taken per cycle unless the result stalls.
// A stalled result holds in the result register while the input register still fills.
// Reset is synchronous and active high; it empties both registers and restores
// the configuration defaults.
// Top level of the ultrasonic echo scanner; depends on ues_pkg, ues_csr and ues_engine.
module ultrasonic_echo_scanner
   import ues_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_WIDTH-1:0]  req_tdata,  // op[1:0], echo_levels[5:2], sensor_select[7:6]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_WIDTH-1:0]  rsp_tdata,  // trigger_lines[3:0], done_res[4], found[5],
                                             // sensor_found[7:6], duration[15:8]
   input  logic                  csr_we,
   input  logic [CSR_AWIDTH-1:0] csr_addr,
   input  logic [CSR_DWIDTH-1:0] csr_wdata
);

   cfg_type cfg;
   req_type req_ff, req_in;
   rsp_type rsp_ff, rsp_in;
   rsp_type step_rsp;
   logic    in_valid_ff, in_valid_in;
   logic    out_valid_ff, out_valid_in;
   logic    advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      req_in = req_ff;
      if (req_tvalid && req_tready) begin
         req_in.op            = req_tdata[1:0];
         req_in.echo_levels   = req_tdata[5:2];
         req_in.sensor_select = req_tdata[7:6];
      end
      in_valid_in = (req_tvalid && req_tready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_in       = advance ? step_rsp : rsp_ff;
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   ues_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ues_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .cfg     (cfg),
      .req     (req_ff),
      .rsp     (step_rsp)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {rsp_ff.duration, rsp_ff.sensor_found, rsp_ff.found,
                        rsp_ff.done_res, rsp_ff.trigger_lines};

endmodule

>>> hw/rtl/ues_checker.sv
// Port-level checker for the ultrasonic echo scanner and its bind statement.
// Depends on ues_pkg for the port widths and the duration limit.
module ues_checker
   import ues_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_WIDTH-1:0]  rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled result word changed or vanished.");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[4] |-> rsp_tdata[15:5] == 11'd0)
      else $error("Result fields set on a word that finishes nothing.");

   a_done_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |->
         rsp_tdata[3:0] == 4'd0 && rsp_tdata[15:8] < 8'(VALID_LIMIT))
      else $error("Finishing word drives a trigger or an out-of-range duration.");

   a_one_trigger: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tdata[3:0]))
      else $error("More than one trigger line is high.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result valid right after reset.");

endmodule

bind ultrasonic_echo_scanner ues_checker u_ues_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
